@@ rtl/mac_al_pkg.sv @@
package mac_al_pkg;

    localparam int MAX_ENTRIES_DEF = 8;
    localparam int MAC_W           = 48;
    localparam int ENTRY_COUNT_W   = 4;

    typedef enum logic {
        FUNC_LOOKUP = 1'b0,
        FUNC_ADD    = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_ADDED     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // request moving down the cell chain, with the match seen so far
    typedef struct packed {
        logic             valid;
        func_t            func;
        logic [MAC_W-1:0] addr;
        logic             hit;
    } link_t;

endpackage

@@ rtl/mac_al_cell.sv @@
module mac_al_cell
    import mac_al_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  link_t            link_in,
    output link_t            link_out,
    input  logic [CNT_W-1:0] count,
    input  logic             wr_en,
    input  logic [MAC_W-1:0] wr_data
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [MAC_W-1:0] entry_reg;
    logic             valid_reg;
    func_t            func_reg;
    logic [MAC_W-1:0] addr_reg;
    logic             hit_reg;
    logic             hit_next;

    // only filled slots take part in the compare
    assign hit_next = link_in.hit || ((IDX_C < count) && (entry_reg == link_in.addr));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= link_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= link_in.func;
        addr_reg <= link_in.addr;
        hit_reg  <= hit_next;
        if (wr_en)
        begin
            entry_reg <= wr_data;
        end
    end

    assign link_out.valid = valid_reg;
    assign link_out.func  = func_reg;
    assign link_out.addr  = addr_reg;
    assign link_out.hit   = hit_reg;

endmodule

@@ rtl/mac_allowlist_table_top.sv @@
// an accepted start sends the request down the cell chain; done is registered from the chain tail
// one transaction at a time: busy stays high until done,
// and the next start is taken in the cycle done is high
// the request walks the cell chain, one cell per cycle
// reset clears the fill count, busy and done; stored addresses are not cleared
// results cannot be stalled: accepted and status hold each result only until the next done
module mac_allowlist_table_top
    import mac_al_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     func,
    input  logic [MAC_W-1:0]         mac_addr,
    output logic                     done,
    output logic                     accepted,
    output logic [1:0]               status,
    output logic [ENTRY_COUNT_W-1:0] entry_count
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ENTRIES);

    link_t                   chain [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0]  wr_sel;

    logic                    busy_reg, busy_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    done_reg;
    logic                    accepted_reg, accepted_next;
    status_t                 status_reg, status_next;
    logic                    append;
    logic                    take;
    logic [CNT_W+ENTRY_COUNT_W-1:0] count_ext;
    link_t                   tail;

    assign take = start && !busy_reg;

    assign chain[0].valid = take;
    assign chain[0].func  = func_t'(func);
    assign chain[0].addr  = mac_addr;
    assign chain[0].hit   = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            assign wr_sel[gi] = append && (count_reg == CNT_W'(gi));

            mac_al_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .link_in  (chain[gi]),
                .link_out (chain[gi+1]),
                .count    (count_reg),
                .wr_en    (wr_sel[gi]),
                .wr_data  (tail.addr)
            );
        end
    endgenerate

    assign tail = chain[MAX_ENTRIES];

    always_comb
    begin
        append        = 1'b0;
        accepted_next = 1'b0;
        status_next   = ST_NOT_FOUND;
        count_next    = count_reg;
        busy_next     = busy_reg;
        if (take)
        begin
            busy_next = 1'b1;
        end
        if (tail.valid)
        begin
            busy_next = 1'b0;
            if (tail.hit)
            begin
                accepted_next = 1'b1;
                status_next   = ST_FOUND;
            end
            else if (tail.func == FUNC_LOOKUP)
            begin
                status_next = ST_NOT_FOUND;
            end
            else if (count_reg == MAX_C)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                append        = 1'b1;
                accepted_next = 1'b1;
                status_next   = ST_ADDED;
                count_next    = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
            done_reg  <= tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.valid)
        begin
            accepted_reg <= accepted_next;
            status_reg   <= status_next;
        end
    end

    assign count_ext   = {{ENTRY_COUNT_W{1'b0}}, count_reg};
    assign busy        = busy_reg;
    assign done        = done_reg;
    assign accepted    = accepted_reg;
    assign status      = status_reg;
    assign entry_count = count_ext[ENTRY_COUNT_W-1:0];

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted start");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg))
        else $error("done without a transaction in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("fill count beyond table size");

    a_added_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_ADDED) |-> (accepted && count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("append without count increment");

endmodule
